// ----- hdl/tcas_pkg.sv -----
// ----------------------------------------------------------------------------
// tcas_pkg
// Shared types, constants and helper functions for the text console with
// ANSI color escapes.
// ----------------------------------------------------------------------------
package tcas_pkg;

    // Screen geometry and parser limits
    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int ESCAPE_LIMIT = 32;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int PARAM_MAX    = 63;

    // Derived widths
    localparam int ADDR_W  = $clog2(CELLS);          // cell address
    localparam int CUR_W   = $clog2(CELLS + 1);      // cursor, can reach CELLS
    localparam int COL_W   = $clog2(COLUMNS);        // column within a row
    localparam int ESC_W   = $clog2(ESCAPE_LIMIT);   // sequence length
    localparam int PARAM_W = $clog2(PARAM_MAX + 1);  // SGR number
    localparam int PROD_W  = PARAM_W + 4;            // number * 10 + digit

    // Fixed field widths on the ports
    localparam int IDX_W   = 11;
    localparam int BYTE_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = BYTE_W + ATTR_W;

    // Byte codes
    localparam logic [BYTE_W-1:0] BYTE_NL     = 8'h0a;
    localparam logic [BYTE_W-1:0] BYTE_ESC    = 8'h1b;
    localparam logic [BYTE_W-1:0] BYTE_LBRACK = 8'h5b;
    localparam logic [BYTE_W-1:0] BYTE_SGR    = 8'h6d;  // 'm'
    localparam logic [BYTE_W-1:0] BYTE_DROP   = 8'h4d;  // 'M'
    localparam logic [BYTE_W-1:0] BYTE_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] BYTE_NINE   = 8'h39;

    // SGR numbers
    localparam logic [PARAM_W-1:0] SGR_RESET      = PARAM_W'(0);
    localparam logic [PARAM_W-1:0] SGR_BRIGHT_OFF = PARAM_W'(1);
    localparam logic [PARAM_W-1:0] SGR_BRIGHT_ON  = PARAM_W'(2);
    localparam logic [PARAM_W-1:0] SGR_FG_BASE    = PARAM_W'(30);
    localparam logic [PARAM_W-1:0] SGR_BG_BASE    = PARAM_W'(40);
    localparam logic [PARAM_W-1:0] SGR_END        = PARAM_W'(50);

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] DEFAULT_CELL = {DEFAULT_ATTR, 8'h00};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_TAIL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;   // latch the accepted item
        logic step;      // run the item against the state
        logic cnt_zero;  // restart the sweep counter
        logic copy;      // one step of the row move
        logic fill;      // write one cell to the default
        logic load;      // move the result into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_scroll;
        logic copy_end;
        logic fill_end;
    } dp_status_t;

    typedef struct packed {
        logic              bright;
        logic [ATTR_W-1:0] attr;
    } sgr_t;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor_pos;
        logic              cell_written;
        logic [IDX_W-1:0]  write_index;
        logic [BYTE_W-1:0] write_glyph;
        logic [ATTR_W-1:0] write_attr;
        logic              scrolled;
        logic [BYTE_W-1:0] read_glyph;
        logic [ATTR_W-1:0] read_attr;
        logic [ATTR_W-1:0] current_attr;
    } result_t;

    function automatic logic [2:0] ansi_color(input logic [3:0] code);
        logic [2:0] c;
        unique case (code)
            4'd0:    c = 3'h0;
            4'd1:    c = 3'h4;
            4'd2:    c = 3'h2;
            4'd3:    c = 3'h6;
            4'd4:    c = 3'h1;
            4'd5:    c = 3'h5;
            4'd6:    c = 3'h3;
            default: c = 3'h7;
        endcase
        return c;
    endfunction

    // Apply one SGR number to the pending color
    function automatic sgr_t apply_sgr(input logic [PARAM_W-1:0] num, input sgr_t cur);
        sgr_t             r;
        logic [PARAM_W-1:0] off;
        logic [3:0]       col;
        r   = cur;
        off = '0;
        priority if (num == SGR_RESET) begin
            r.bright = 1'b0;
            r.attr   = DEFAULT_ATTR;
        end else if (num == SGR_BRIGHT_ON) begin
            r.bright = 1'b1;
        end else if (num == SGR_BRIGHT_OFF) begin
            r.bright = 1'b0;
        end else if (num >= SGR_BG_BASE && num < SGR_END) begin
            off    = num - SGR_BG_BASE;
            col    = {cur.bright, ansi_color(off[3:0])};
            r.attr = {col, cur.attr[3:0]};
        end else if (num >= SGR_FG_BASE && num < SGR_BG_BASE) begin
            off    = num - SGR_FG_BASE;
            col    = {cur.bright, ansi_color(off[3:0])};
            r.attr = {cur.attr[7:4], col};
        end
        return r;
    endfunction

endpackage

// ----- hdl/text_console_ansi_sgr.sv -----
// ----------------------------------------------------------------------------
// text_console_ansi_sgr
// Text console with an 80x25 cell store and ANSI SGR color escapes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transaction per console byte or cell read.
//   s_tuser selects the kind: 0 writes a console byte (newline, glyph or part
//   of an ESC [ ... m sequence), 1 reads one screen cell.
//   Result stream (m_*): exactly one transaction per input transaction, in
//   order, carrying cursor, write report, scroll flag, read cell and the
//   current attribute.
//   Timing: an item is accepted, executed in the next cycle and then moved
//   into the output register once that register is free; no new item is
//   taken before that load. A byte that moves the cursor past the last cell
//   scrolls the store through the cell memory before the load: the rows are
//   moved up by one row, then the bottom row is cleared.
//   Reset: aresetn low clears cursor, attribute and parser; after release a
//   clearing pass writes every cell, s_tready stays low during it.
//   Stall: a result held in the output register while m_tready is low blocks
//   only the handoff of the next result; the next item is still accepted
//   and executed, then waits until the output register frees up.
// ----------------------------------------------------------------------------
module text_console_ansi_sgr
    import tcas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // byte_in[7:0], cell_index[18:8], zero pad
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // cursor_pos[10:0], cell_written[11],
                                   // write_index[22:12], write_glyph[30:23],
                                   // write_attr[38:31], scrolled[39],
                                   // read_glyph[47:40], read_attr[55:48],
                                   // current_attr[63:56]
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    result_t    result;
    logic       out_free;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg;

    // The output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    tcas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    tcas_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_kind  (s_tuser),
        .in_byte  (s_tdata[7:0]),
        .in_idx   (s_tdata[18:8]),
        .status   (status),
        .result   (result)
    );

    // Hold the result until the receiver takes it; load on handoff
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_data_reg <= {result.current_attr, result.read_attr, result.read_glyph,
                           result.scrolled, result.write_attr, result.write_glyph,
                           result.write_index, result.cell_written, result.cursor_pos};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A scroll always leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[39]) |-> (m_tdata[10:0] == IDX_W'(CELLS - COLUMNS)))
        else $error("scroll result with cursor off the bottom row");

    // A console byte never reports read data
    a_write_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[11]) |-> (m_tdata[55:40] == 16'h0000))
        else $error("glyph write reported read data");

    // No item is taken while the clearing pass runs after reset
    a_clear_blocks: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("input accepted during clearing pass");

    // A result is loaded only into a free output slot
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> out_free)
        else $error("result loaded over a pending result");

endmodule

// ----- hdl/tcas_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcas_ctrl
// Sequencer: clearing pass, item execution, scroll sweep and result handoff.
// ----------------------------------------------------------------------------
module tcas_ctrl
    import tcas_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       out_free,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.fill = 1'b1;
                if (status.fill_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.step = 1'b1;
                if (status.need_scroll) begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = ST_COPY;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY: begin
                cmd.copy = 1'b1;
                if (status.copy_end) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                cmd.fill = 1'b1;
                if (status.fill_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/tcas_datapath.sv -----
// ----------------------------------------------------------------------------
// tcas_datapath
// Cell store, cursor, escape parser registers and sweep counter.
// ----------------------------------------------------------------------------
module tcas_datapath
    import tcas_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_cmd_t         cmd,
    input  logic              in_kind,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic [IDX_W-1:0]  in_idx,
    output dp_status_t        status,
    output result_t           result
);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    logic              kind_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [CUR_W-1:0]   cursor_reg,  cursor_next;
    logic [COL_W-1:0]   col_reg,     col_next;
    logic [ATTR_W-1:0]  attr_reg,    attr_next;
    logic [ESC_W-1:0]   esc_reg,     esc_next;
    logic [PARAM_W-1:0] param_reg,   param_next;
    logic               digit_reg,   digit_next;
    sgr_t               pend_reg,    pend_next;
    logic [ADDR_W-1:0]  cnt_reg,     cnt_next;

    logic              written_reg, written_next;
    logic [ADDR_W-1:0] windex_reg,  windex_next;
    logic [BYTE_W-1:0] wglyph_reg,  wglyph_next;
    logic [ATTR_W-1:0] wattr_reg,   wattr_next;
    logic              scroll_reg,  scroll_next;
    logic              rdok_reg,    rdok_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    logic               dec_char;
    logic [PROD_W-1:0]  prod;
    logic [BYTE_W-1:0]  dval;
    sgr_t               applied;
    logic               copy_end, fill_end;

    assign copy_end = (cnt_reg == ADDR_W'(CELLS - COLUMNS));
    assign fill_end = (cnt_reg == ADDR_W'(CELLS - 1));

    assign dec_char = (byte_reg >= BYTE_ZERO) && (byte_reg <= BYTE_NINE);
    assign dval     = byte_reg - BYTE_ZERO;
    assign prod     = (PROD_W'(param_reg) << 3) + (PROD_W'(param_reg) << 1)
                    + PROD_W'(dval[3:0]);
    assign applied  = apply_sgr(param_reg, pend_reg);

    always_comb begin
        cursor_next  = cursor_reg;
        col_next     = col_reg;
        attr_next    = attr_reg;
        esc_next     = esc_reg;
        param_next   = param_reg;
        digit_next   = digit_reg;
        pend_next    = pend_reg;
        cnt_next     = cnt_reg;
        written_next = written_reg;
        windex_next  = windex_reg;
        wglyph_next  = wglyph_reg;
        wattr_next   = wattr_reg;
        scroll_next  = scroll_reg;
        rdok_next    = rdok_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        status       = '0;
        status.copy_end = copy_end;
        status.fill_end = fill_end;

        if (cmd.step) begin
            written_next = 1'b0;
            windex_next  = '0;
            wglyph_next  = '0;
            wattr_next   = '0;
            scroll_next  = 1'b0;
            rdok_next    = 1'b0;
            if (kind_reg) begin
                rdok_next = (32'(idx_reg) < 32'(CELLS));
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(idx_reg);
            end else begin
                priority if (byte_reg == BYTE_NL) begin
                    cursor_next = cursor_reg + CUR_W'(COLUMNS) - CUR_W'(col_reg);
                    col_next    = '0;
                end else if (byte_reg == BYTE_ESC) begin
                    esc_next = ESC_W'(1);
                end else if (esc_reg == ESC_W'(1) && byte_reg == BYTE_LBRACK) begin
                    esc_next    = ESC_W'(2);
                    param_next  = '0;
                    digit_next  = 1'b0;
                    pend_next   = '{bright: 1'b0, attr: attr_reg};
                end else if (esc_reg >= ESC_W'(2)) begin
                    if (esc_reg >= ESC_W'(ESCAPE_LIMIT - 1)) begin
                        esc_next = '0;
                    end else begin
                        esc_next = esc_reg + ESC_W'(1);
                        priority if (dec_char) begin
                            param_next = (prod > PROD_W'(PARAM_MAX)) ?
                                         PARAM_W'(PARAM_MAX) : prod[PARAM_W-1:0];
                            digit_next = 1'b1;
                        end else if (byte_reg == BYTE_SGR) begin
                            if (digit_reg) begin
                                pend_next = applied;
                                attr_next = applied.attr;
                            end else begin
                                attr_next = pend_reg.attr;
                            end
                            esc_next = '0;
                        end else if (byte_reg == BYTE_DROP) begin
                            esc_next = '0;
                        end else begin
                            // any other byte ends the number
                            pend_next  = applied;
                            param_next = '0;
                            digit_next = 1'b0;
                        end
                    end
                end else begin
                    esc_next     = '0;
                    mem_we       = 1'b1;
                    mem_waddr    = cursor_reg[ADDR_W-1:0];
                    mem_wdata    = {attr_reg, byte_reg};
                    written_next = 1'b1;
                    windex_next  = cursor_reg[ADDR_W-1:0];
                    wglyph_next  = byte_reg;
                    wattr_next   = attr_reg;
                    cursor_next  = cursor_reg + CUR_W'(1);
                    col_next     = (col_reg == COL_W'(COLUMNS - 1)) ?
                                   '0 : col_reg + COL_W'(1);
                end
                if (cursor_next == CUR_W'(CELLS)) begin
                    status.need_scroll = 1'b1;
                    scroll_next        = 1'b1;
                    cursor_next        = CUR_W'(CELLS - COLUMNS);
                    col_next           = '0;
                end
            end
        end

        if (cmd.cnt_zero) begin
            cnt_next = '0;
        end

        if (cmd.copy) begin
            // read one row ahead, write the value read last cycle
            if (!copy_end) begin
                mem_re    = 1'b1;
                mem_raddr = cnt_reg + ADDR_W'(COLUMNS);
                cnt_next  = cnt_reg + ADDR_W'(1);
            end
            if (cnt_reg != '0) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg - ADDR_W'(1);
                mem_wdata = rdata_reg;
            end
        end

        if (cmd.fill) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg;
            mem_wdata = DEFAULT_CELL;
            cnt_next  = fill_end ? '0 : cnt_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= in_kind;
            byte_reg <= in_byte;
            idx_reg  <= in_idx;
        end
        written_reg <= written_next;
        windex_reg  <= windex_next;
        wglyph_reg  <= wglyph_next;
        wattr_reg   <= wattr_next;
        scroll_reg  <= scroll_next;
        rdok_reg    <= rdok_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            col_reg    <= '0;
            attr_reg   <= DEFAULT_ATTR;
            esc_reg    <= '0;
            param_reg  <= '0;
            digit_reg  <= 1'b0;
            pend_reg   <= '{bright: 1'b0, attr: DEFAULT_ATTR};
            cnt_reg    <= '0;
        end else begin
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            attr_reg   <= attr_next;
            esc_reg    <= esc_next;
            param_reg  <= param_next;
            digit_reg  <= digit_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_comb begin
        result.cursor_pos   = IDX_W'(cursor_reg);
        result.cell_written = written_reg;
        result.write_index  = IDX_W'(windex_reg);
        result.write_glyph  = wglyph_reg;
        result.write_attr   = wattr_reg;
        result.scrolled     = scroll_reg;
        result.read_glyph   = rdok_reg ? rdata_reg[BYTE_W-1:0] : '0;
        result.read_attr    = rdok_reg ? rdata_reg[CELL_W-1:BYTE_W] : '0;
        result.current_attr = attr_reg;
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ANSI text console: drives console bytes and
// cell reads, predicts each result transaction and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import tcas_pkg::*;

    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 20;

    localparam bit KIND_BYTE = 1'b0;
    localparam bit KIND_READ = 1'b1;

    // Characters used to build escape sequences
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3b;
    localparam logic [BYTE_W-1:0] CH_STRAY = 8'h78;  // 'x'

    typedef logic [IDX_W-1:0]  cell_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct {
        bit      kind;
        byte_t   data_byte;
        cell_t   cell_idx;
        bit      pinned;    // use the typed-in result instead of the prediction
        result_t known;
    } stim_row_t;

    typedef enum int {
        SEG_SGR, SEG_TEXT, SEG_NEWLINE, SEG_READ, SEG_OVERLONG, SEG_BROKEN, SEG_NOISE
    } segment_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [23:0]   s_tdata;   // byte_in[7:0], cell_index[18:8], zero pad
    logic          s_tuser;   // kind
    logic          m_tvalid;
    logic          m_tready;
    logic [63:0]   m_tdata;   // cursor_pos .. current_attr, see the block's port list

    text_console_ansi_sgr uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the console
    byte_t       shadow_glyph [CELLS];
    byte_t       shadow_attr  [CELLS];
    int unsigned con_cursor;
    byte_t       con_attr;
    int unsigned seq_len;
    int unsigned sgr_num;
    bit          sgr_digits;
    byte_t       sgr_pending;
    bit          sgr_bright;

    result_t     awaited_reports [$];
    stim_row_t   stim_q [$];

    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    int unsigned items_sent    = 0;
    int unsigned bytes_sent    = 0;
    int unsigned reads_sent    = 0;
    int unsigned sgr_commits   = 0;
    int unsigned scroll_total  = 0;
    int unsigned reports_seen  = 0;
    bit          fast_sender   = 1'b0;

    // ------------------------------------------------------------------
    // Console prediction
    // ------------------------------------------------------------------
    function automatic logic [2:0] vga_hue(int unsigned ansi);
        case (ansi)
            0:       return 3'h0;
            1:       return 3'h4;
            2:       return 3'h2;
            3:       return 3'h6;
            4:       return 3'h1;
            5:       return 3'h5;
            6:       return 3'h3;
            default: return 3'h7;
        endcase
    endfunction

    // Fold one SGR number into the pending color
    function automatic void fold_sgr(int unsigned num);
        logic [3:0] col;
        if (num == 0) begin
            sgr_bright  = 1'b0;
            sgr_pending = DEFAULT_ATTR;
        end else if (num == 2) begin
            sgr_bright = 1'b1;
        end else if (num == 1) begin
            sgr_bright = 1'b0;
        end else if (num >= 30 && num < 50) begin
            col = {1'b0, vga_hue((num - 30) % 10)} + (sgr_bright ? 4'd8 : 4'd0);
            if (num >= 40)
                sgr_pending = {col, sgr_pending[3:0]};
            else
                sgr_pending = {sgr_pending[7:4], col};
        end
    endfunction

    function automatic void console_reset();
        for (int i = 0; i < CELLS; i++) begin
            shadow_glyph[i] = 8'h00;
            shadow_attr[i]  = DEFAULT_ATTR;
        end
        con_cursor  = 0;
        con_attr    = DEFAULT_ATTR;
        seq_len     = 0;
        sgr_num     = 0;
        sgr_digits  = 1'b0;
        sgr_pending = DEFAULT_ATTR;
        sgr_bright  = 1'b0;
    endfunction

    // Advance the shadow console by one transaction and return its report
    function automatic result_t console_step(bit kind, byte_t b, cell_t idx);
        result_t r;
        r = '0;
        if (kind == KIND_READ) begin
            if (idx < CELLS) begin
                r.read_glyph = shadow_glyph[idx];
                r.read_attr  = shadow_attr[idx];
            end
        end else begin
            if (b == BYTE_NL) begin
                con_cursor += COLUMNS - (con_cursor % COLUMNS);
            end else if (b == BYTE_ESC) begin
                seq_len = 1;
            end else if (seq_len == 1 && b == BYTE_LBRACK) begin
                seq_len     = 2;
                sgr_num     = 0;
                sgr_digits  = 1'b0;
                sgr_pending = con_attr;
                sgr_bright  = 1'b0;
            end else if (seq_len >= 2) begin
                if (seq_len >= ESCAPE_LIMIT - 1) begin
                    seq_len = 0;   // swallow the byte, drop the sequence
                end else begin
                    seq_len++;
                    if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
                        sgr_num = sgr_num * 10 + (b - BYTE_ZERO);
                        if (sgr_num > PARAM_MAX)
                            sgr_num = PARAM_MAX;
                        sgr_digits = 1'b1;
                    end else if (b == BYTE_SGR) begin
                        if (sgr_digits)
                            fold_sgr(sgr_num);
                        con_attr = sgr_pending;
                        seq_len  = 0;
                        sgr_commits++;
                    end else if (b == BYTE_DROP) begin
                        seq_len = 0;
                    end else begin
                        fold_sgr(sgr_num);
                        sgr_num    = 0;
                        sgr_digits = 1'b0;
                    end
                end
            end else begin
                seq_len = 0;
                if (con_cursor < CELLS) begin
                    shadow_glyph[con_cursor] = b;
                    shadow_attr[con_cursor]  = con_attr;
                end
                r.cell_written = 1'b1;
                r.write_index  = IDX_W'(con_cursor);
                r.write_glyph  = b;
                r.write_attr   = con_attr;
                con_cursor++;
            end
            if (con_cursor >= CELLS) begin
                for (int i = 0; i < CELLS - COLUMNS; i++) begin
                    shadow_glyph[i] = shadow_glyph[i + COLUMNS];
                    shadow_attr[i]  = shadow_attr[i + COLUMNS];
                end
                for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                    shadow_glyph[i] = 8'h00;
                    shadow_attr[i]  = DEFAULT_ATTR;
                end
                con_cursor = CELLS - COLUMNS;
                r.scrolled = 1'b1;
                scroll_total++;
            end
        end
        r.cursor_pos   = IDX_W'(con_cursor);
        r.current_attr = con_attr;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic result_t known_result(int unsigned cur, bit wr, int unsigned widx,
                                             byte_t wglyph, byte_t wattr,
                                             byte_t rglyph, byte_t rattr, byte_t attr);
        result_t r;
        r = '0;
        r.cursor_pos   = IDX_W'(cur);
        r.cell_written = wr;
        r.write_index  = IDX_W'(widx);
        r.write_glyph  = wglyph;
        r.write_attr   = wattr;
        r.read_glyph   = rglyph;
        r.read_attr    = rattr;
        r.current_attr = attr;
        return r;
    endfunction

    function automatic void queue_item(bit kind, byte_t b, cell_t idx,
                                       bit pinned = 1'b0, result_t known = '0);
        stim_row_t row;
        row.kind      = kind;
        row.data_byte = b;
        row.cell_idx  = idx;
        row.pinned    = pinned;
        row.known     = known;
        stim_q.push_back(row);
    endfunction

    // The unused field still gets random bits
    function automatic void queue_byte(byte_t b);
        queue_item(KIND_BYTE, b, cell_t'($urandom_range(0, 2047)));
    endfunction

    function automatic void queue_read(int unsigned idx);
        queue_item(KIND_READ, byte_t'($urandom_range(0, 255)), cell_t'(idx));
    endfunction

    // Push a decimal number, sometimes with a leading zero
    function automatic void queue_number(int unsigned v);
        if ($urandom_range(0, 7) == 0)
            queue_byte(BYTE_ZERO);
        if (v >= 100)
            queue_byte(BYTE_ZERO + byte_t'(v / 100));
        if (v >= 10)
            queue_byte(BYTE_ZERO + byte_t'((v / 10) % 10));
        queue_byte(BYTE_ZERO + byte_t'(v % 10));
    endfunction

    // Any byte that the parser treats as a plain separator
    function automatic byte_t stray_byte();
        byte_t b;
        do
            b = byte_t'($urandom_range(0, 255));
        while ((b >= BYTE_ZERO && b <= BYTE_NINE) || b == BYTE_SGR || b == BYTE_DROP ||
               b == BYTE_ESC || b == BYTE_NL);
        return b;
    endfunction

    function automatic int unsigned sender_gap();
        int unsigned r;
        if (fast_sender)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Present one transaction, wait for the handshake, record its report.
    // Enter and leave at a falling edge.
    task automatic send_item(input stim_row_t row);
        int unsigned gap;
        result_t     want;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.kind;
        s_tdata  <= {5'b0, row.cell_idx, row.data_byte};
        do
            @(posedge aclk);
        while (s_tready !== 1'b1);
        want = console_step(row.kind, row.data_byte, row.cell_idx);
        if (row.pinned)
            want = row.known;
        awaited_reports.push_back(want);
        items_sent++;
        if (row.kind == KIND_READ)
            reads_sent++;
        else
            bytes_sent++;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            reports_seen++;
            if (awaited_reports.size() == 0) begin
                $error("result transaction 0x%0h arrived with nothing outstanding", m_tdata);
                mismatches++;
            end else begin
                want = awaited_reports.pop_front();
                check_field("cursor_pos",   want.cursor_pos,   m_tdata[10:0]);
                check_field("cell_written", want.cell_written, m_tdata[11]);
                check_field("write_index",  want.write_index,  m_tdata[22:12]);
                check_field("write_glyph",  want.write_glyph,  m_tdata[30:23]);
                check_field("write_attr",   want.write_attr,   m_tdata[38:31]);
                check_field("scrolled",     want.scrolled,     m_tdata[39]);
                check_field("read_glyph",   want.read_glyph,   m_tdata[47:40]);
                check_field("read_attr",    want.read_attr,    m_tdata[55:48]);
                check_field("current_attr", want.current_attr, m_tdata[63:56]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Clock, watchdog and result-side back-pressure
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The clearing pass after reset and every scroll each sweep the whole cell
    // store; the limit leaves plenty of room for both.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("watchdog expired with %0d results outstanding", awaited_reports.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Alternate open windows with stalls; some windows run long without a stall
    initial begin
        int unsigned open_len;
        int unsigned stall_len;
        m_tready = 1'b0;
        forever begin
            open_len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (open_len) @(negedge aclk);
            stall_len = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(1, 3);
            m_tready <= 1'b0;
            repeat (stall_len) @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned r;
        int unsigned n;
        int unsigned v;
        int unsigned goal;
        bit          held_once;
        segment_t    seg;

        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        aresetn   = 1'b0;
        held_once = 1'b0;
        console_reset();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows: reads right after reset (first cell, past the store),
        // glyph extremes, an SGR run with bright, saturation and a stray
        // separator, a newline, an empty-number reset, and ESC not followed by '['.
        queue_read(0);
        stim_q[$].pinned = 1'b1;
        stim_q[$].known  = known_result(0, 0, 0, 0, 0, 8'h00, DEFAULT_ATTR, DEFAULT_ATTR);
        queue_read(2047);
        stim_q[$].pinned = 1'b1;
        stim_q[$].known  = known_result(0, 0, 0, 0, 0, 8'h00, 8'h00, DEFAULT_ATTR);
        queue_byte(8'h41);
        stim_q[$].pinned = 1'b1;
        stim_q[$].known  = known_result(1, 1, 0, 8'h41, DEFAULT_ATTR, 0, 0, DEFAULT_ATTR);
        queue_byte(8'hff);
        queue_byte(8'h00);
        stim_q[$].pinned = 1'b1;
        stim_q[$].known  = known_result(3, 1, 2, 8'h00, DEFAULT_ATTR, 0, 0, DEFAULT_ATTR);
        queue_read(1);
        queue_byte(BYTE_ESC);
        queue_byte(BYTE_LBRACK);
        queue_byte(BYTE_ZERO + 8'd2);
        queue_byte(CH_SEMI);
        queue_byte(BYTE_NINE);
        queue_byte(BYTE_NINE);
        queue_byte(CH_STRAY);
        queue_byte(BYTE_ZERO + 8'd3);
        queue_byte(BYTE_ZERO + 8'd1);
        queue_byte(BYTE_SGR);
        queue_byte(BYTE_NL);
        queue_byte(BYTE_ESC);
        queue_byte(BYTE_LBRACK);
        queue_byte(CH_SEMI);
        queue_byte(BYTE_SGR);
        queue_byte(BYTE_ESC);
        queue_byte(8'h41);

        goal = stim_q.size() + RANDOM_ITEMS;
        while (stim_q.size() != 0)
            send_item(stim_q.pop_front());

        // Random part: mostly well-formed sequences and text, some noise
        while (items_sent < goal) begin
            fast_sender = ($urandom_range(0, 6) == 0);
            r = $urandom_range(0, 99);
            seg = (r < 32) ? SEG_SGR      :
                  (r < 58) ? SEG_TEXT     :
                  (r < 72) ? SEG_NEWLINE  :
                  (r < 84) ? SEG_READ     :
                  (r < 88) ? SEG_OVERLONG :
                  (r < 95) ? SEG_BROKEN   : SEG_NOISE;
            case (seg)
                SEG_SGR: begin
                    queue_byte(BYTE_ESC);
                    queue_byte(BYTE_LBRACK);
                    n = $urandom_range(0, 4);
                    for (int i = 0; i < n; i++) begin
                        if (i > 0)
                            queue_byte(($urandom_range(0, 7) == 0) ? stray_byte() : CH_SEMI);
                        if ($urandom_range(0, 15) == 0)
                            queue_byte(BYTE_NL);   // newline inside the sequence
                        case ($urandom_range(0, 9))
                            0:       v = 0;
                            1:       v = 1;
                            2:       v = 2;
                            3, 4:    v = 30 + $urandom_range(0, 9);
                            5, 6:    v = 40 + $urandom_range(0, 9);
                            7:       v = $urandom_range(0, 99);
                            8:       v = $urandom_range(100, 999);
                            default: v = 1000;     // empty number
                        endcase
                        if (v < 1000)
                            queue_number(v);
                    end
                    r = $urandom_range(0, 19);
                    if (r < 17)
                        queue_byte(BYTE_SGR);
                    else if (r < 19)
                        queue_byte(BYTE_DROP);
                end
                SEG_TEXT: begin
                    // From the bottom row, sometimes run off the last cell (up to three bytes beyond it)
                    if (con_cursor >= CELLS - COLUMNS && $urandom_range(0, 2) == 0)
                        n = CELLS - con_cursor + $urandom_range(0, 3);
                    else if ($urandom_range(0, 9) == 0)
                        n = $urandom_range(40, 100);
                    else
                        n = $urandom_range(1, 24);
                    for (int i = 0; i < n; i++)
                        queue_byte(($urandom_range(0, 3) != 0) ?
                                   byte_t'($urandom_range(8'h20, 8'h7e)) :
                                   byte_t'($urandom_range(0, 255)));
                end
                SEG_NEWLINE: begin
                    n = $urandom_range(2, 8);
                    for (int i = 0; i < n; i++)
                        queue_byte(BYTE_NL);
                end
                SEG_READ: begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) begin
                        r = $urandom_range(0, 19);
                        if (r < 8)
                            queue_read($urandom_range(0, CELLS - 1));
                        else if (r < 14)
                            queue_read((con_cursor > 0) ? con_cursor - 1 : 0);
                        else if (r < 17)
                            queue_read($urandom_range(CELLS - COLUMNS, CELLS - 1));
                        else
                            queue_read($urandom_range(CELLS, 2047));
                    end
                end
                SEG_OVERLONG: begin
                    queue_byte(BYTE_ESC);
                    queue_byte(BYTE_LBRACK);
                    n = $urandom_range(ESCAPE_LIMIT - 5, ESCAPE_LIMIT + 2);
                    for (int i = 0; i < n; i++)
                        queue_byte(($urandom_range(0, 3) == 0) ? CH_SEMI :
                                   BYTE_ZERO + byte_t'($urandom_range(0, 9)));
                    if ($urandom_range(0, 1) == 0)
                        queue_byte(BYTE_SGR);
                end
                SEG_BROKEN: begin
                    case ($urandom_range(0, 3))
                        0: begin   // ESC restarts the sequence
                            queue_byte(BYTE_ESC);
                            queue_byte(BYTE_LBRACK);
                            queue_number(30 + $urandom_range(0, 19));
                            queue_byte(BYTE_ESC);
                            queue_byte(BYTE_LBRACK);
                            queue_number(30 + $urandom_range(0, 19));
                            queue_byte(BYTE_SGR);
                        end
                        1: begin   // newline between number and terminator
                            queue_byte(BYTE_ESC);
                            queue_byte(BYTE_LBRACK);
                            queue_number(40 + $urandom_range(0, 9));
                            queue_byte(BYTE_NL);
                            queue_byte(BYTE_SGR);
                        end
                        2: begin   // ESC followed by anything
                            queue_byte(BYTE_ESC);
                            queue_byte(byte_t'($urandom_range(0, 255)));
                        end
                        default: begin   // leave a sequence open
                            queue_byte(BYTE_ESC);
                            queue_byte(BYTE_LBRACK);
                            queue_number($urandom_range(0, 49));
                        end
                    endcase
                end
                default: begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++)
                        queue_item(bit'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)),
                                   cell_t'($urandom_range(0, 2047)));
                end
            endcase

            while (stim_q.size() != 0)
                send_item(stim_q.pop_front());

            // Hold the input once until the block has caught up completely
            if (!held_once && items_sent >= goal - RANDOM_ITEMS / 2) begin
                held_once = 1'b1;
                s_tvalid <= 1'b0;
                while (awaited_reports.size() != 0)
                    @(negedge aclk);
            end
        end

        // Drain: wait for every outstanding result
        s_tvalid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d console bytes and %0d cell reads, %0d results checked.",
                 bytes_sent, reads_sent, reports_seen);
        $display("Color commits: %0d, scrolls: %0d, field mismatches: %0d.",
                 sgr_commits, scroll_total, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
